// File: hdl/bud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_pkg
// Shared codes, defaults and types for the bounded undo deque.
// ----------------------------------------------------------------------------
package bud_pkg;

  localparam int DEPTH_DEFAULT       = 16;
  localparam int ENTRY_WIDTH_DEFAULT = 32;
  localparam int CAP_W               = 5;
  localparam int MODE_W              = 2;
  localparam int SRC_W               = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_TAIL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_HEAD = 2'd2;

  localparam logic [SRC_W-1:0] SRC_EVICT = 2'd0;
  localparam logic [SRC_W-1:0] SRC_TAIL  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_HEAD  = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] source;
    logic             err;
  } res_req_t;

endpackage
`default_nettype wire

// File: hdl/bud_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_ram
// Entry ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bud_ram #(
  parameter int DEPTH       = bud_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_WIDTH = bud_pkg::ENTRY_WIDTH_DEFAULT,
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [IDX_W-1:0]       waddr,
  input  wire logic [ENTRY_WIDTH-1:0] wdata,
  input  wire logic                   re,
  input  wire logic [IDX_W-1:0]       raddr,
  output logic      [ENTRY_WIDTH-1:0] rdata
);

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/bud_ptr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_ptr
// Head pointer, entry count and capacity register; decodes each item into
// ring reads and writes and the result it will give.
// ----------------------------------------------------------------------------
module bud_ptr #(
  parameter int DEPTH  = bud_pkg::DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [bud_pkg::CAP_W-1:0]  cfg_capacity,
  input  wire logic                       take,
  input  wire logic [bud_pkg::MODE_W-1:0] mode,
  output logic                            mem_we,
  output logic      [IDX_W-1:0]           mem_waddr,
  output logic                            mem_re,
  output logic      [IDX_W-1:0]           mem_raddr,
  output bud_pkg::res_req_t               req
);

  localparam int CW  = (CNT_W > bud_pkg::CAP_W) ? CNT_W : bud_pkg::CAP_W;
  localparam int SUM_W = CNT_W + 1;

  logic [bud_pkg::CAP_W-1:0] cap_r;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic [CW-1:0]    cap_ext;
  logic [CNT_W-1:0] cap_eff;
  logic [SUM_W-1:0] sum_hc, sum_hc1;
  logic [IDX_W-1:0] tail_wr, tail_rd, head_inc;
  logic             empty, full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bud_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_capacity;
    end
  end

  always_comb begin
    cap_ext = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_ext[CNT_W-1:0];
    end
  end

  always_comb begin
    sum_hc  = SUM_W'(head_r) + SUM_W'(cnt_r);
    sum_hc1 = sum_hc - SUM_W'(1);
    if (sum_hc >= SUM_W'(DEPTH)) begin
      tail_wr = IDX_W'(sum_hc - SUM_W'(DEPTH));
    end else begin
      tail_wr = IDX_W'(sum_hc);
    end
    if (sum_hc1 >= SUM_W'(DEPTH)) begin
      tail_rd = IDX_W'(sum_hc1 - SUM_W'(DEPTH));
    end else begin
      tail_rd = IDX_W'(sum_hc1);
    end
    if (head_r == IDX_W'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_r + IDX_W'(1);
    end
    empty = (cnt_r == '0);
    full  = (cnt_r >= cap_eff) && !empty;
  end

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = tail_wr;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    req.valid  = 1'b0;
    req.source = bud_pkg::SRC_EVICT;
    req.err    = 1'b0;
    if (take) begin
      unique case (mode)
        bud_pkg::MODE_PUSH: begin
          mem_we = 1'b1;
          if (full) begin
            mem_re    = 1'b1;
            req.valid = 1'b1;
            head_nxt  = head_inc;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        bud_pkg::MODE_POP_TAIL: begin
          req.valid  = 1'b1;
          req.source = bud_pkg::SRC_TAIL;
          if (empty) begin
            req.err = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = tail_rd;
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end
        bud_pkg::MODE_POP_HEAD: begin
          req.valid  = 1'b1;
          req.source = bud_pkg::SRC_HEAD;
          if (empty) begin
            req.err = 1'b1;
          end else begin
            mem_re   = 1'b1;
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bud_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bud_out
// Read-wait stage and output register for result items.
// ----------------------------------------------------------------------------
module bud_out #(
  parameter int ENTRY_WIDTH = bud_pkg::ENTRY_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      take,
  input  wire bud_pkg::res_req_t         req,
  input  wire logic [ENTRY_WIDTH-1:0]    rdata,
  output logic                           busy,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic      [ENTRY_WIDTH-1:0]    out_result_value,
  output logic      [bud_pkg::SRC_W-1:0] out_result_source,
  output logic                           out_empty_error
);

  logic                      pend_r, pend_nxt;
  logic [bud_pkg::SRC_W-1:0] pend_src_r;
  logic                      pend_err_r;
  logic                      oval_r, oval_nxt;
  logic [ENTRY_WIDTH-1:0]    oval_data_r;
  logic [bud_pkg::SRC_W-1:0] osrc_r;
  logic                      oerr_r;
  logic                      out_free;

  always_comb begin
    out_free = !oval_r || !out_stall;
    busy     = pend_r && !out_free;
    oval_nxt = out_free ? pend_r : oval_r;
    if (take) begin
      pend_nxt = req.valid;
    end else if (out_free) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_src_r <= req.source;
      pend_err_r <= req.err;
    end
    if (out_free && pend_r) begin
      oval_data_r <= pend_err_r ? '0 : rdata;
      osrc_r      <= pend_src_r;
      oerr_r      <= pend_err_r;
    end
  end

  assign out_valid         = oval_r;
  assign out_result_value  = oval_data_r;
  assign out_result_source = osrc_r;
  assign out_empty_error   = oerr_r;

endmodule
`default_nettype wire

// File: hdl/bounded_undo_deque_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_undo_deque_unit
// Bounded double-ended undo history kept in a ring memory.
// ----------------------------------------------------------------------------
// Accepts one item per cycle while in_stall is low: pointer and count update
// in the accept cycle, and the ring memory is read then. in_stall rises only
// while a result waits in the read stage and the output register is held by
// out_stall. cfg_ready is always high; write capacity only while the block is
// idle. Capacity zero acts as one, capacity above DEPTH as DEPTH. No clearing
// pass after reset.
module bounded_undo_deque_unit #(
  parameter int DEPTH       = bud_pkg::DEPTH_DEFAULT,
  parameter int ENTRY_WIDTH = bud_pkg::ENTRY_WIDTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bud_pkg::CAP_W-1:0]  cfg_capacity,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [bud_pkg::MODE_W-1:0] in_mode,
  input  wire logic [ENTRY_WIDTH-1:0]     in_entry_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [ENTRY_WIDTH-1:0]     out_result_value,
  output logic      [bud_pkg::SRC_W-1:0]  out_result_source,
  output logic                            out_empty_error
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                   take, busy;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [ENTRY_WIDTH-1:0] rdata;
  bud_pkg::res_req_t      req;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign take      = in_valid && !busy;

  bud_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_capacity (cfg_capacity),
    .take         (take),
    .mode         (in_mode),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .req          (req)
  );

  bud_ram #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_entry_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  bud_out #(
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (take),
    .req               (req),
    .rdata             (rdata),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_result_source (out_result_source),
    .out_empty_error   (out_empty_error)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded undo deque unit. A scoreboard class
// keeps its own copy of the ring, head, count and capacity, works out the
// evicted or removed word for every accepted item and checks each result
// item in order. Directed corners come first: empty pops, the unused mode,
// extreme words, and capacity lowered below the count. Randomised fill and
// drain runs follow over several capacity settings and idle patterns, with
// one long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import bud_pkg::*;

  localparam int EW = ENTRY_WIDTH_DEFAULT;
  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENT_ITEMS = 150;
  localparam int NUM_SEGMENTS = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [EW-1:0]    value;
    logic [SRC_W-1:0] source;
    logic             err;
  } outcome_t;

  class deque_scoreboard;
    logic [EW-1:0]    ring [DEPTH];
    int unsigned      head;
    int unsigned      count;
    logic [CAP_W-1:0] capacity;
    outcome_t         owed [$];
    int               errors;
    int               checked;

    function new();
      head = 0;
      count = 0;
      capacity = CAP_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void owe(logic [EW-1:0] value, logic [SRC_W-1:0] source, logic err);
      outcome_t o;
      o.value = value;
      o.source = source;
      o.err = err;
      owed.push_back(o);
    endfunction

    function void apply_operation(logic [MODE_W-1:0] mode, logic [EW-1:0] word);
      int unsigned limit;
      limit = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : capacity;
      case (mode)
        MODE_PUSH: begin
          if (count >= limit && count > 0) begin
            owe(ring[head], SRC_EVICT, 1'b0);
            head = (head + 1) % DEPTH;
            count--;
          end
          ring[(head + count) % DEPTH] = word;
          count++;
        end
        MODE_POP_TAIL, MODE_POP_HEAD: begin
          if (count == 0) begin
            owe('0, (mode == MODE_POP_TAIL) ? SRC_TAIL : SRC_HEAD, 1'b1);
          end else if (mode == MODE_POP_HEAD) begin
            owe(ring[head], SRC_HEAD, 1'b0);
            head = (head + 1) % DEPTH;
            count--;
          end else begin
            count--;
            owe(ring[(head + count) % DEPTH], SRC_TAIL, 1'b0);
          end
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [EW-1:0] value, logic [SRC_W-1:0] source, logic err);
      outcome_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected item value %h source %0d error %b", value, source, err));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (value !== want.value)
        report($sformatf("value %h, wanted %h", value, want.value));
      if (source !== want.source)
        report($sformatf("source %0d, wanted %0d", source, want.source));
      if (err !== want.err)
        report($sformatf("empty error %b, wanted %b", err, want.err));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_capacity = CAP_RESET;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode = MODE_PUSH;
  logic [EW-1:0]         in_entry_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [EW-1:0]         out_result_value;
  logic [SRC_W-1:0]      out_result_source;
  logic                  out_empty_error;

  deque_scoreboard       sb;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  bit                    hold_active = 1'b0;
  int                    items_sent = 0;
  int                    settings_done = 0;
  int                    cycle_count = 0;
  logic [CAP_W-1:0]      cap_plan [NUM_SEGMENTS] =
    '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3, 5'd8};

  always #1 clk = ~clk;

  bounded_undo_deque_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_result_source (out_result_source),
    .out_empty_error   (out_empty_error)
  );

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [EW-1:0] word);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_entry_value <= word;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.apply_operation(mode, word);
    if (mode != MODE_IGNORED) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.capacity = cap;
    settings_done++;
  endtask

  task automatic run_random(input int n);
    int               sent;
    int               pick;
    bit               filling;
    logic [MODE_W-1:0] mode;
    logic [EW-1:0]    word;
    sent = 0;
    while (sent < n) begin
      filling = ((sent / 40) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 6) mode = MODE_IGNORED;
      else if (pick < (filling ? 80 : 30)) mode = MODE_PUSH;
      else if (pick < (filling ? 90 : 65)) mode = MODE_POP_TAIL;
      else mode = MODE_POP_HEAD;
      case ($urandom_range(9))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      send_item(mode, word);
      if (mode != MODE_IGNORED) sent++;
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(out_result_value, out_result_source, out_empty_error);
      out_stall <= hold_active ||
                   (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin : main
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops, unused mode, extreme words
    send_item(MODE_POP_TAIL, 32'h1234_5678);
    send_item(MODE_POP_HEAD, 32'hffff_ffff);
    send_item(MODE_IGNORED, 32'hdead_beef);
    send_item(MODE_PUSH, 32'h0000_0000);
    send_item(MODE_PUSH, 32'hffff_ffff);
    send_item(MODE_PUSH, 32'h5a5a_a5a5);
    send_item(MODE_POP_TAIL, '0);
    send_item(MODE_POP_HEAD, '0);
    send_item(MODE_POP_HEAD, '0);
    send_item(MODE_POP_HEAD, '0);
    for (int i = 0; i < 6; i++) send_item(MODE_PUSH, 32'h1000_0000 + i);

    // capacity lowered below the count
    wait_idle();
    write_capacity(5'd3);
    send_item(MODE_PUSH, 32'ha5a5_5a5a);
    send_item(MODE_PUSH, 32'h0f0f_f0f0);
    wait_idle();
    write_capacity(5'd1);
    send_item(MODE_PUSH, 32'h8000_0001);
    send_item(MODE_POP_TAIL, '0);
    send_item(MODE_POP_HEAD, '0);

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      wait_idle();
      write_capacity(cap_plan[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (seg == 4) begin
        fork
          begin
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
          end
        join_none
      end
      run_random(SEGMENT_ITEMS);
    end

    wait_idle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("run covered %0d items and %0d checked results over %0d capacity writes",
             items_sent, sb.checked, settings_done);
    $display("including empty pops, evictions, lowered capacity and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (sb.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bud_pkg.sv
hdl/bud_ram.sv
hdl/bud_ptr.sv
hdl/bud_out.sv
hdl/bounded_undo_deque_unit.sv
tb/testbench.sv
